/* src/dsw_pkg.sv */
// Shared constants and types for the dusk switch with manual override.
package dsw_pkg;

    // Configuration register widths
    localparam int MARGIN_BITS = 12;
    localparam int TICKS_BITS  = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HYST_MARGIN   = 3'd0,
        CFG_LONG_PRESS    = 3'd1,
        CFG_OFF_DWELL     = 3'd2,
        CFG_ON_DWELL      = 3'd3,
        CFG_START_LAMP_ON = 3'd4
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic [MARGIN_BITS-1:0] HYST_MARGIN_RST = 12'd5;
    localparam logic [TICKS_BITS-1:0]  LONG_PRESS_RST  = 16'd50;
    localparam logic [TICKS_BITS-1:0]  OFF_DWELL_RST   = 16'd1000;
    localparam logic [TICKS_BITS-1:0]  ON_DWELL_RST    = 16'd500;
    localparam logic                   START_LAMP_RST  = 1'b1;

    // One result word
    typedef struct packed {
        logic lamp_on;
        logic override_active;
        logic lamp_command;
    } result_t;

endpackage

/* src/dusk_switch_with_override.sv */
// Top level of the dusk switch with manual override: tick logic and output buffering.
//
// Channels: the tick channel (in_valid / in_stall) carries button_down,
//   ambient_level and threshold_level; the result channel (out_valid / out_stall)
//   carries lamp_on, override_active and lamp_command, one word per tick. The
//   configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   the margin, long-press and dwell registers; cfg_ready is always high. Write
//   only while no tick is in flight.
// Throughput: a result word is registered into the output register, or the skid
//   register under a stall; one tick per cycle is sustained while in_stall is low,
//   as the counters and flags update in the accepting cycle from a single adder/compare stage.
// Stalls: an output register plus a skid register keep the input open for one
//   more word while the receiver stalls; in_stall rises only when both are full.
// Reset: rst_n clears the counters and override, turns the lamp on, loads the
//   register reset values (margin 5, long press 50, off dwell 1000, on dwell
//   500) and empties the output buffer. A write to start_lamp_on is accepted
//   but the lamp always resets to that register's reset value.
module dusk_switch_with_override #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // tick channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          button_down,
    input  logic [SAMPLE_BITS-1:0]        ambient_level,
    input  logic [SAMPLE_BITS-1:0]        threshold_level,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          lamp_on,
    output logic                          override_active,
    output logic                          lamp_command,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dsw_pkg::*;

    // Signed width holding threshold +/- margin and the light sample
    localparam int SUM_W = ((SAMPLE_BITS > MARGIN_BITS) ? SAMPLE_BITS : MARGIN_BITS) + 2;
    // Width for comparing counters against 16-bit tick registers
    localparam int CMP_W = (COUNT_BITS > TICKS_BITS) ? COUNT_BITS : TICKS_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration registers
    logic [MARGIN_BITS-1:0] margin_reg;
    logic [TICKS_BITS-1:0]  long_press_reg;
    logic [TICKS_BITS-1:0]  off_dwell_reg;
    logic [TICKS_BITS-1:0]  on_dwell_reg;

    // Tick state
    logic                  lamp_reg, lamp_next;
    logic                  ovr_reg, ovr_next;
    logic [COUNT_BITS-1:0] press_reg, press_next;
    logic [COUNT_BITS-1:0] bright_reg, bright_next;
    logic [COUNT_BITS-1:0] dark_reg, dark_next;
    logic                  cmd_next;

    // Output buffer
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_word_reg;
    result_t skid_word_reg;
    result_t res_word;

    logic in_acc;
    logic out_take;

    logic signed [SUM_W-1:0] light_s;
    logic signed [SUM_W-1:0] thr_s;
    logic signed [SUM_W-1:0] margin_s;
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    logic                    is_bright;
    logic                    is_dark;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_acc    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    // Write configuration registers; start_lamp_on only matters at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg     <= HYST_MARGIN_RST;
            long_press_reg <= LONG_PRESS_RST;
            off_dwell_reg  <= OFF_DWELL_RST;
            on_dwell_reg   <= ON_DWELL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HYST_MARGIN: margin_reg     <= cfg_data[MARGIN_BITS-1:0];
                CFG_LONG_PRESS:  long_press_reg <= cfg_data[TICKS_BITS-1:0];
                CFG_OFF_DWELL:   off_dwell_reg  <= cfg_data[TICKS_BITS-1:0];
                CFG_ON_DWELL:    on_dwell_reg   <= cfg_data[TICKS_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Form the light thresholds with signed arithmetic
    always_comb
    begin
        light_s   = signed'(SUM_W'(ambient_level));
        thr_s     = signed'(SUM_W'(threshold_level));
        margin_s  = signed'(SUM_W'(margin_reg));
        hi_lim    = thr_s + margin_s;
        lo_lim    = thr_s - margin_s;
        is_bright = light_s > hi_lim;
        is_dark   = light_s < lo_lim;
    end

    // Advance the tick state for one word
    always_comb
    begin
        lamp_next   = lamp_reg;
        ovr_next    = ovr_reg;
        press_next  = press_reg;
        bright_next = bright_reg;
        dark_next   = dark_reg;
        cmd_next    = 1'b0;

        if (button_down)
        begin
            press_next = (press_reg == COUNT_MAX) ? COUNT_MAX : press_reg + 1'b1;
        end
        else
        begin
            // Classify the release
            if (CMP_W'(press_reg) > CMP_W'(long_press_reg))
            begin
                ovr_next = 1'b0;
            end
            else if (press_reg != '0)
            begin
                ovr_next  = 1'b1;
                lamp_next = !lamp_reg;
                cmd_next  = 1'b1;
            end
            press_next = '0;

            // Run the dusk logic when not overridden
            if (!ovr_next)
            begin
                if (is_bright && lamp_next)
                begin
                    bright_next = (bright_reg == COUNT_MAX) ? COUNT_MAX : bright_reg + 1'b1;
                    if (CMP_W'(bright_reg) > CMP_W'(off_dwell_reg))
                    begin
                        lamp_next   = 1'b0;
                        cmd_next    = 1'b1;
                        bright_next = '0;
                    end
                end
                else if (is_dark && !lamp_next)
                begin
                    dark_next = (dark_reg == COUNT_MAX) ? COUNT_MAX : dark_reg + 1'b1;
                    if (CMP_W'(dark_reg) > CMP_W'(on_dwell_reg))
                    begin
                        lamp_next = 1'b1;
                        cmd_next  = 1'b1;
                        dark_next = '0;
                    end
                end
                else
                begin
                    bright_next = '0;
                    dark_next   = '0;
                end
            end
        end

        res_word.lamp_on         = lamp_next;
        res_word.override_active = ovr_next;
        res_word.lamp_command    = cmd_next;
    end

    // Commit the tick state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_reg   <= START_LAMP_RST;
            ovr_reg    <= 1'b0;
            press_reg  <= '0;
            bright_reg <= '0;
            dark_reg   <= '0;
        end
        else if (in_acc)
        begin
            lamp_reg   <= lamp_next;
            ovr_reg    <= ovr_next;
            press_reg  <= press_next;
            bright_reg <= bright_next;
            dark_reg   <= dark_next;
        end
    end

    // Hold result words in the output register and the skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_acc)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Move payload along the output buffer
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_word_reg <= skid_word_reg;
            end
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_word_reg <= res_word;
            end
            else
            begin
                skid_word_reg <= res_word;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign lamp_on         = out_word_reg.lamp_on;
    assign override_active = out_word_reg.override_active;
    assign lamp_command    = out_word_reg.lamp_command;

endmodule

/* src/dsw_checker.sv */
// Port-level checker for the dusk switch, bound to the top level.
module dsw_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic lamp_on,
    input logic override_active,
    input logic lamp_command
);

    // The input only stalls when a result word is waiting
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // After an accepted word the output always holds a valid result word next cycle
    a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted word did not reach the output");

    // A stalled result word stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result word dropped under stall");

    // A stalled result word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            ($stable(lamp_on) && $stable(override_active) && $stable(lamp_command)))
        else $error("result payload changed under stall");

endmodule

bind dusk_switch_with_override dsw_checker u_dsw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .lamp_on         (lamp_on),
    .override_active (override_active),
    .lamp_command    (lamp_command)
);

/* dv/tb_dusk_switch_with_override.sv */
// Testbench for the dusk switch with manual override: directed and random ticks checked against a predictor.
module tb_dusk_switch_with_override;
    import dsw_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
    localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;
    // Indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_HI = 3'd7;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_TICKS   = 140;
    // About 1.4k ticks, each at worst behind the longest source gap and the longest sink stall, taken 7x
    localparam int CYCLE_LIMIT   = 400_000;

    typedef struct packed {
        logic                   button;
        logic [SAMPLE_BITS-1:0] light;
        logic [SAMPLE_BITS-1:0] thr;
    } tick_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   button_down = 1'b0;
    logic [SAMPLE_BITS-1:0] ambient_level = '0;
    logic [SAMPLE_BITS-1:0] threshold_level = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   lamp_on;
    logic                   override_active;
    logic                   lamp_command;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor copy of the registers and the switch state
    logic [MARGIN_BITS-1:0] cur_margin     = HYST_MARGIN_RST;
    logic [TICKS_BITS-1:0]  cur_long_press = LONG_PRESS_RST;
    logic [TICKS_BITS-1:0]  cur_off_dwell  = OFF_DWELL_RST;
    logic [TICKS_BITS-1:0]  cur_on_dwell   = ON_DWELL_RST;
    logic                   cur_start_lamp = START_LAMP_RST;
    logic                   lamp_st        = START_LAMP_RST;
    logic                   override_st    = 1'b0;
    logic [COUNT_BITS-1:0]  press_cnt      = '0;
    logic [COUNT_BITS-1:0]  bright_cnt     = '0;
    logic [COUNT_BITS-1:0]  dark_cnt       = '0;

    tick_t   tick_q[$];
    result_t lamp_expect_q[$];
    tick_t   next_tick;
    result_t want;
    int      ticks_outstanding = 0;
    int      phase_ticks = 0;
    int      src_gap = 0;
    int      sink_gap = 0;
    int      err_cnt = 0;
    int      cycle_cnt = 0;
    logic    idle_on = 1'b1;

    dusk_switch_with_override #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [COUNT_BITS-1:0] sat_step(logic [COUNT_BITS-1:0] v);
        return (v == COUNT_SAT) ? v : v + 1'b1;
    endfunction

    // Advance the switch state by one tick and return the word it produces
    function automatic result_t dusk_tick(tick_t t);
        result_t               r;
        int                    light;
        int                    thr;
        int                    margin;
        logic [COUNT_BITS-1:0] old;
        light = int'(t.light);
        thr = int'(t.thr);
        margin = int'(cur_margin);
        r.lamp_command = 1'b0;
        if (t.button)
        begin
            press_cnt = sat_step(press_cnt);
        end
        else
        begin
            if (press_cnt > cur_long_press)
            begin
                override_st = 1'b0;
            end
            else if (press_cnt != '0)
            begin
                override_st = 1'b1;
                lamp_st = !lamp_st;
                r.lamp_command = 1'b1;
            end
            press_cnt = '0;
            // light logic runs only without override
            if (!override_st)
            begin
                if (light > thr + margin && lamp_st)
                begin
                    old = bright_cnt;
                    bright_cnt = sat_step(bright_cnt);
                    if (old > cur_off_dwell)
                    begin
                        lamp_st = 1'b0;
                        r.lamp_command = 1'b1;
                        bright_cnt = '0;
                    end
                end
                else if (light < thr - margin && !lamp_st)
                begin
                    old = dark_cnt;
                    dark_cnt = sat_step(dark_cnt);
                    if (old > cur_on_dwell)
                    begin
                        lamp_st = 1'b1;
                        r.lamp_command = 1'b1;
                        dark_cnt = '0;
                    end
                end
                else
                begin
                    bright_cnt = '0;
                    dark_cnt = '0;
                end
            end
        end
        r.lamp_on = lamp_st;
        r.override_active = override_st;
        return r;
    endfunction

    // Predict each accepted tick word, then present the next one or idle
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                lamp_expect_q.push_back(dusk_tick({button_down, ambient_level, threshold_level}));
                ticks_outstanding--;
            end
            if (!in_valid || !in_stall)
            begin
                if (src_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 19);
                if (src_gap != 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (tick_q.size() != 0)
                begin
                    next_tick = tick_q.pop_front();
                    in_valid <= 1'b1;
                    button_down <= next_tick.button;
                    ambient_level <= next_tick.light;
                    threshold_level <= next_tick.thr;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result channel in random bursts
    always @(posedge clk)
    begin
        if (sink_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
            sink_gap = $urandom_range(1, 19);
        if (sink_gap != 0)
        begin
            sink_gap--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Check each accepted result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (lamp_expect_q.size() == 0)
            begin
                $display("%0t: result word with nothing expected: lamp_on %0b override %0b cmd %0b",
                         $time, lamp_on, override_active, lamp_command);
                err_cnt++;
            end
            else
            begin
                want = lamp_expect_q.pop_front();
                if (lamp_on !== want.lamp_on)
                begin
                    $display("%0t: lamp_on expected %0b actual %0b", $time, want.lamp_on, lamp_on);
                    err_cnt++;
                end
                if (override_active !== want.override_active)
                begin
                    $display("%0t: override_active expected %0b actual %0b",
                             $time, want.override_active, override_active);
                    err_cnt++;
                end
                if (lamp_command !== want.lamp_command)
                begin
                    $display("%0t: lamp_command expected %0b actual %0b",
                             $time, want.lamp_command, lamp_command);
                    err_cnt++;
                end
            end
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("dusk_switch_with_override verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HYST_MARGIN:   cur_margin = data[MARGIN_BITS-1:0];
            CFG_LONG_PRESS:    cur_long_press = data[TICKS_BITS-1:0];
            CFG_OFF_DWELL:     cur_off_dwell = data[TICKS_BITS-1:0];
            CFG_ON_DWELL:      cur_on_dwell = data[TICKS_BITS-1:0];
            CFG_START_LAMP_ON: cur_start_lamp = data[0];
            default: ;
        endcase
    endtask

    task automatic push_tick(logic button, int light, int thr);
        tick_q.push_back({button, light[SAMPLE_BITS-1:0], thr[SAMPLE_BITS-1:0]});
        ticks_outstanding++;
        phase_ticks++;
    endtask

    // Wait until every tick is accepted and every result word has come back
    task automatic wait_drain();
        while (ticks_outstanding != 0 || lamp_expect_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Queue one sequence: a press, a bright or dark run, a band visit or noise
    task automatic queue_episode();
        int kind;
        int len;
        int lo;
        int hi;
        int cap;
        int m;
        int t;
        int i;
        m = int'(cur_margin);
        kind = $urandom_range(0, 9);
        if (kind <= 2)
        begin
            // press length around the long-press bound
            if (cur_long_press > 60)
            begin
                len = $urandom_range(0, 60);
            end
            else
            begin
                lo = (cur_long_press > 2) ? int'(cur_long_press) - 2 : 0;
                hi = int'(cur_long_press) + 2;
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, hi) : $urandom_range(lo, hi);
            end
            for (i = 0; i < len; i++)
                push_tick(1'b1, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
            push_tick(1'b0, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
        end
        else if (kind <= 6)
        begin
            // bright or dark run, long enough to pass a small dwell
            cap = (kind <= 4) ? int'(cur_off_dwell) : int'(cur_on_dwell);
            if (cap > 40)
                cap = 40;
            len = $urandom_range(1, cap + 3);
            for (i = 0; i < len; i++)
            begin
                if (m >= SAMPLE_MAX)
                begin
                    push_tick(1'b0, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
                end
                else if (kind <= 4)
                begin
                    t = $urandom_range(0, SAMPLE_MAX - 1 - m);
                    push_tick(1'b0, $urandom_range(t + m + 1, SAMPLE_MAX), t);
                end
                else
                begin
                    t = $urandom_range(m + 1, SAMPLE_MAX);
                    push_tick(1'b0, $urandom_range(0, t - m - 1), t);
                end
            end
        end
        else if (kind == 7)
        begin
            // light inside the hysteresis band
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++)
            begin
                t = $urandom_range(0, SAMPLE_MAX);
                lo = (t - m < 0) ? 0 : t - m;
                hi = (t + m > SAMPLE_MAX) ? SAMPLE_MAX : t + m;
                push_tick(1'b0, $urandom_range(lo, hi), t);
            end
        end
        else
        begin
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++)
                push_tick(1'($urandom_range(0, 1)), $urandom_range(0, SAMPLE_MAX),
                          $urandom_range(0, SAMPLE_MAX));
        end
    endtask

    initial
    begin
        int ph;
        int i;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: bright ticks count but stay far below the dwell
        push_tick(1'b0, SAMPLE_MAX, 0);
        push_tick(1'b0, SAMPLE_MAX, 0);
        wait_drain();

        write_reg(CFG_HYST_MARGIN, 16'd100);
        write_reg(CFG_LONG_PRESS, 16'd3);
        write_reg(CFG_OFF_DWELL, 16'd0);
        write_reg(CFG_ON_DWELL, 16'd0);
        write_reg(CFG_START_LAMP_ON, 16'd0);

        // threshold plus margin past the sample range must not wrap
        push_tick(1'b0, SAMPLE_MAX, 4000);
        // bright run turns the lamp off
        push_tick(1'b0, SAMPLE_MAX, 0);
        push_tick(1'b0, SAMPLE_MAX, 0);
        // threshold minus margin below zero must stay negative
        push_tick(1'b0, 0, 50);
        // dark run turns the lamp on
        push_tick(1'b0, 0, SAMPLE_MAX);
        push_tick(1'b0, 0, SAMPLE_MAX);
        // short press: override on, lamp toggled
        push_tick(1'b1, SAMPLE_MAX, SAMPLE_MAX);
        push_tick(1'b1, 0, 0);
        push_tick(1'b0, SAMPLE_MAX, 0);
        // override on: light is ignored
        push_tick(1'b0, 0, SAMPLE_MAX);
        // long press clears override, light logic runs on release
        for (i = 0; i < 4; i++)
            push_tick(1'b1, 0, SAMPLE_MAX);
        push_tick(1'b0, 0, SAMPLE_MAX);
        // press of exactly the bound still counts as short
        for (i = 0; i < 3; i++)
            push_tick(1'b1, 2048, 2048);
        push_tick(1'b0, 2048, 2048);
        for (i = 0; i < 4; i++)
            push_tick(1'b1, 2048, 2048);
        push_tick(1'b0, 2048, 2048);

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drain();
            case (ph)
                0:
                begin
                    write_reg(CFG_HYST_MARGIN, 16'hFFFF);
                    write_reg(CFG_LONG_PRESS, 16'd0);
                    write_reg(CFG_OFF_DWELL, 16'd0);
                    write_reg(CFG_ON_DWELL, 16'd0);
                    write_reg(CFG_START_LAMP_ON, 16'hFFFE);
                end
                1:
                begin
                    write_reg(CFG_HYST_MARGIN, 16'd0);
                    write_reg(CFG_LONG_PRESS, 16'd65534);
                    write_reg(CFG_OFF_DWELL, 16'd65534);
                    write_reg(CFG_ON_DWELL, 16'd65534);
                    write_reg(CFG_START_LAMP_ON, 16'hFFFF);
                end
                default:
                begin
                    write_reg(CFG_HYST_MARGIN, ($urandom_range(0, 3) == 0)
                                               ? CFG_DATA_W'($urandom)
                                               : CFG_DATA_W'($urandom_range(0, 80)));
                    write_reg(CFG_LONG_PRESS, CFG_DATA_W'($urandom_range(0, 12)));
                    write_reg(CFG_OFF_DWELL, CFG_DATA_W'($urandom_range(0, 20)));
                    write_reg(CFG_ON_DWELL, CFG_DATA_W'($urandom_range(0, 20)));
                    write_reg(CFG_START_LAMP_ON, CFG_DATA_W'($urandom));
                end
            endcase
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_IDX_W'($urandom_range(CFG_NONE_LO, CFG_NONE_HI)),
                          CFG_DATA_W'($urandom));
            // no idling in the last phase, and none in some others
            idle_on = (ph < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            phase_ticks = 0;
            while (phase_ticks < PHASE_TICKS)
                queue_episode();
        end

        wait_drain();
        if (err_cnt == 0)
            $display("dusk_switch_with_override verification clean");
        else
            $display("dusk_switch_with_override verification failed");
        $finish;
    end

endmodule
